// ----- hdl/cylinder_support_point_top_assert.svh -----
// Assertion macros for the cylinder support point checker.
`ifndef CYLINDER_SUPPORT_POINT_TOP_ASSERT_SVH
`define CYLINDER_SUPPORT_POINT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cylinder support point: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cylinder support point: next-cycle check failed");

`endif

// ----- hdl/csp_pkg.sv -----
// Types, constants and arithmetic steps of the cylinder support point block.
`default_nettype none
package csp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 32;
  localparam int NUM_DIV = 5;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_HALF   = 2'd1;
  localparam logic [1:0] CFG_TINY   = 2'd2;

  localparam logic [30:0] ONE_Q = 31'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        margin_amount;
  } in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } out_t;

  // One bit of the floor square root: returns {remainder, root}.
  function automatic logic [127:0] isqrt_step(input logic [63:0] v, input logic [63:0] r,
                                              input logic [63:0] b);
    logic [63:0] t;
    t = r + b;
    if (v >= t) begin
      isqrt_step = {v - t, (r >> 1) + b};
    end else begin
      isqrt_step = {v, r >> 1};
    end
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [33:0] signed_q(input logic [31:0] q, input logic neg);
    logic signed [33:0] t;
    t = $signed({2'b00, q});
    signed_q = neg ? -t : t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/cylinder_support_point_top.sv -----
// Cylinder support point: a 69-stage pipeline of squares, roots and divisions.
// Throughput: one item per cycle while the output is not stalled; each root and quotient bit is one stage.
// The whole pipeline stalls together while a finished item waits at the output.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
`default_nettype none
module cylinder_support_point_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire csp_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output csp_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [62:0]  cfg_data
);
  import csp_pkg::*;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [30:0]        margin;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
    logic [63:0]        sqz;
  } sqr_t;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [30:0]        margin;
    logic               tiny_ok;
    logic [63:0]        vxz;
    logic [63:0]        rxz;
    logic [63:0]        vs;
    logic [63:0]        rs;
  } root_t;

  typedef struct packed {
    logic              sx;
    logic              sy;
    logic              sz;
    logic              lxz_nz;
    logic              use_m;
    logic              fb;
    logic [30:0]       margin;
    logic [31:0]       lxz;
    logic [31:0]       l;
    logic [NUM_DIV-1:0][63:0] prod;
  } mul_t;

  typedef struct packed {
    logic              sx;
    logic              sy;
    logic              sz;
    logic              lxz_nz;
    logic              use_m;
    logic              fb;
    logic [30:0]       margin;
    logic [31:0]       lxz;
    logic [31:0]       l;
    logic [NUM_DIV-1:0][63:0] rem;
    logic [NUM_DIV-1:0][31:0] quo;
  } div_t;

  logic [30:0] radius_r;
  logic [30:0] half_r;
  logic [62:0] tiny_r;

  logic en;

  sqr_t  sqr_r;
  logic  sqr_v_r;
  root_t rt_r [0:SQRT_STEPS];
  logic  rt_v_r [0:SQRT_STEPS];
  mul_t  mul_r;
  logic  mul_v_r;
  div_t  dv_r [0:DIV_STEPS];
  logic  dv_v_r [0:DIV_STEPS];
  out_t  out_r;
  logic  out_v_r;

  assign en        = !out_v_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= ONE_Q;
      half_r   <= ONE_Q;
      tiny_r   <= 63'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_data[30:0];
        CFG_HALF:   half_r   <= cfg_data[30:0];
        CFG_TINY:   tiny_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Squares of the component magnitudes.
  logic [31:0] in_mx, in_my, in_mz;
  assign in_mx = mag32(in_data.dir_x);
  assign in_my = mag32(in_data.dir_y);
  assign in_mz = mag32(in_data.dir_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqr_v_r <= 1'b0;
    end else if (en) begin
      sqr_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqr_r.dx     <= in_data.dir_x;
      sqr_r.dy     <= in_data.dir_y;
      sqr_r.dz     <= in_data.dir_z;
      sqr_r.margin <= in_data.margin_amount;
      sqr_r.sqx    <= {32'd0, in_mx} * {32'd0, in_mx};
      sqr_r.sqy    <= {32'd0, in_my} * {32'd0, in_my};
      sqr_r.sqz    <= {32'd0, in_mz} * {32'd0, in_mz};
    end
  end

  // Sums of squares enter the root pipeline.
  logic [63:0] sum_xz, sum_all;
  assign sum_xz  = sqr_r.sqx + sqr_r.sqz;
  assign sum_all = sum_xz + sqr_r.sqy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_v_r[0] <= 1'b0;
    end else if (en) begin
      rt_v_r[0] <= sqr_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_r[0].dx      <= sqr_r.dx;
      rt_r[0].dy      <= sqr_r.dy;
      rt_r[0].dz      <= sqr_r.dz;
      rt_r[0].margin  <= sqr_r.margin;
      rt_r[0].tiny_ok <= sum_all > {1'b0, tiny_r};
      rt_r[0].vxz     <= sum_xz;
      rt_r[0].rxz     <= 64'd0;
      rt_r[0].vs      <= sum_all;
      rt_r[0].rs      <= 64'd0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [127:0] st_xz, st_s;
    assign st_xz = isqrt_step(rt_r[k].vxz, rt_r[k].rxz, BIT);
    assign st_s  = isqrt_step(rt_r[k].vs, rt_r[k].rs, BIT);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[k+1] <= 1'b0;
      end else if (en) begin
        rt_v_r[k+1] <= rt_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[k+1].dx      <= rt_r[k].dx;
        rt_r[k+1].dy      <= rt_r[k].dy;
        rt_r[k+1].dz      <= rt_r[k].dz;
        rt_r[k+1].margin  <= rt_r[k].margin;
        rt_r[k+1].tiny_ok <= rt_r[k].tiny_ok;
        rt_r[k+1].vxz     <= st_xz[127:64];
        rt_r[k+1].rxz     <= st_xz[63:0];
        rt_r[k+1].vs      <= st_s[127:64];
        rt_r[k+1].rs      <= st_s[63:0];
      end
    end
  end

  // Numerators: scale times component magnitude.
  logic [31:0] rt_mx, rt_my, rt_mz, rt_lxz, rt_l;
  assign rt_mx  = mag32(rt_r[SQRT_STEPS].dx);
  assign rt_my  = mag32(rt_r[SQRT_STEPS].dy);
  assign rt_mz  = mag32(rt_r[SQRT_STEPS].dz);
  assign rt_lxz = rt_r[SQRT_STEPS].rxz[31:0];
  assign rt_l   = rt_r[SQRT_STEPS].rs[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (en) begin
      mul_v_r <= rt_v_r[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_r.sx      <= rt_r[SQRT_STEPS].dx[31];
      mul_r.sy      <= rt_r[SQRT_STEPS].dy[31];
      mul_r.sz      <= rt_r[SQRT_STEPS].dz[31];
      mul_r.lxz_nz  <= rt_lxz != 32'd0;
      mul_r.use_m   <= (rt_r[SQRT_STEPS].margin != 31'd0) && rt_r[SQRT_STEPS].tiny_ok
                       && (rt_l != 32'd0);
      mul_r.fb      <= (rt_r[SQRT_STEPS].margin != 31'd0)
                       && !(rt_r[SQRT_STEPS].tiny_ok && (rt_l != 32'd0));
      mul_r.margin  <= rt_r[SQRT_STEPS].margin;
      mul_r.lxz     <= rt_lxz;
      mul_r.l       <= rt_l;
      mul_r.prod[0] <= {33'd0, radius_r} * {32'd0, rt_mx};
      mul_r.prod[1] <= {33'd0, radius_r} * {32'd0, rt_mz};
      mul_r.prod[2] <= {33'd0, rt_r[SQRT_STEPS].margin} * {32'd0, rt_mx};
      mul_r.prod[3] <= {33'd0, rt_r[SQRT_STEPS].margin} * {32'd0, rt_my};
      mul_r.prod[4] <= {33'd0, rt_r[SQRT_STEPS].margin} * {32'd0, rt_mz};
    end
  end

  // Rounding bias of half the divisor, then the long divisions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0].sx     <= mul_r.sx;
      dv_r[0].sy     <= mul_r.sy;
      dv_r[0].sz     <= mul_r.sz;
      dv_r[0].lxz_nz <= mul_r.lxz_nz;
      dv_r[0].use_m  <= mul_r.use_m;
      dv_r[0].fb     <= mul_r.fb;
      dv_r[0].margin <= mul_r.margin;
      dv_r[0].lxz    <= mul_r.lxz;
      dv_r[0].l      <= mul_r.l;
      dv_r[0].rem[0] <= mul_r.prod[0] + {33'd0, mul_r.lxz[31:1]};
      dv_r[0].rem[1] <= mul_r.prod[1] + {33'd0, mul_r.lxz[31:1]};
      dv_r[0].rem[2] <= mul_r.prod[2] + {33'd0, mul_r.l[31:1]};
      dv_r[0].rem[3] <= mul_r.prod[3] + {33'd0, mul_r.l[31:1]};
      dv_r[0].rem[4] <= mul_r.prod[4] + {33'd0, mul_r.l[31:1]};
      dv_r[0].quo    <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - k;
    logic [NUM_DIV-1:0][63:0] sub;
    logic [NUM_DIV-1:0]       fit;

    always_comb begin
      for (int j = 0; j < NUM_DIV; j++) begin
        sub[j] = (j < 2) ? ({32'd0, dv_r[k].lxz} << SH) : ({32'd0, dv_r[k].l} << SH);
        fit[j] = dv_r[k].rem[j] >= sub[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1].sx     <= dv_r[k].sx;
        dv_r[k+1].sy     <= dv_r[k].sy;
        dv_r[k+1].sz     <= dv_r[k].sz;
        dv_r[k+1].lxz_nz <= dv_r[k].lxz_nz;
        dv_r[k+1].use_m  <= dv_r[k].use_m;
        dv_r[k+1].fb     <= dv_r[k].fb;
        dv_r[k+1].margin <= dv_r[k].margin;
        dv_r[k+1].lxz    <= dv_r[k].lxz;
        dv_r[k+1].l      <= dv_r[k].l;
        for (int j = 0; j < NUM_DIV; j++) begin
          dv_r[k+1].rem[j] <= fit[j] ? dv_r[k].rem[j] - sub[j] : dv_r[k].rem[j];
          dv_r[k+1].quo[j] <= dv_r[k].quo[j] | (32'(fit[j]) << SH);
        end
      end
    end
  end

  // Sign, sum and saturate.
  div_t fin;
  logic signed [33:0] px_sum, py_sum, pz_sum, half_s;
  out_t out_nxt;

  assign fin = dv_r[DIV_STEPS];

  always_comb begin
    half_s = $signed({3'b000, half_r});
    if (fin.sy) begin
      half_s = -half_s;
    end
    px_sum = (fin.lxz_nz ? signed_q(fin.quo[0], fin.sx) : 34'sd0)
           + (fin.use_m ? signed_q(fin.quo[2], fin.sx) : 34'sd0);
    pz_sum = (fin.lxz_nz ? signed_q(fin.quo[1], fin.sz) : 34'sd0)
           + (fin.use_m ? signed_q(fin.quo[4], fin.sz) : 34'sd0);
    py_sum = half_s
           + (fin.use_m ? signed_q(fin.quo[3], fin.sy) : 34'sd0)
           + (fin.fb ? $signed({3'b000, fin.margin}) : 34'sd0);
    out_nxt.point_x = sat32(px_sum);
    out_nxt.point_y = sat32(py_sum);
    out_nxt.point_z = sat32(pz_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/csp_checker.sv -----
// Port-level checker for the cylinder support point top level, with its bind.
`default_nettype none
`include "cylinder_support_point_top_assert.svh"
module csp_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire csp_pkg::out_t out_data
);
  // A waiting result item holds still until taken.
  `CSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // The pipeline only refuses an item while a result item is stuck.
  `CSP_ASSERT_IMPLY(a_ready_free, !in_ready, out_valid && !out_ready)
  // A stuck result item always blocks the input side.
  `CSP_ASSERT_IMPLY(a_stall_blocks, out_valid && !out_ready, !in_ready)
endmodule

bind cylinder_support_point_top csp_checker u_csp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
